// ===== hdl/hbss_pkg.sv =====
// ----------------------------------------------------------------------------
// hbss_pkg: types and constants of the homing step sequencer
// Transaction payload structs, request codes and fixed timing constants.
// ----------------------------------------------------------------------------
package hbss_pkg;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [2:0] CFG_STEPS_X = 3'd0;
  localparam logic [2:0] CFG_STEPS_Y = 3'd1;
  localparam logic [2:0] CFG_STEPS_Z = 3'd2;
  localparam logic [2:0] CFG_STEPS_U = 3'd3;
  localparam logic [2:0] CFG_PULSE   = 3'd4;
  localparam logic [2:0] CFG_BASE    = 3'd5;

  localparam logic [31:0] USEC_PER_MIN = 32'd60000000;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  axis_mask;
    logic        positive_dir;
    logic        invert_limits;
    logic [31:0] cruise_period_us;
    logic [31:0] rate_increment;
    logic [3:0]  limit_bits;
    logic        abort;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  step_mask;
    logic [7:0]  pin_word;
    logic [31:0] post_pulse_delay_us;
    logic        done_res;
  } out_item_t;

endpackage

// ===== hdl/homing_bresenham_step_sequencer_top.sv =====
// Every result is registered and offered in the cycle after its transaction is taken.
// Throughput: one transaction per cycle; a tick that advances the ramp blocks the input
// through the ST_DIV and ST_FIN states until the 32-bit bit-serial divide is done.
// A stalled result blocks the input only while the result register stays full.
// Reset (rst_n low, synchronous): pass state cleared, pulse width set to 10.
// ----------------------------------------------------------------------------
// homing_bresenham_step_sequencer_top: homing step sequencer
// Four-axis Bresenham step generator with a trapezoid ramp of the step rate.
// ----------------------------------------------------------------------------
module homing_bresenham_step_sequencer_top #(
  parameter int MIN_STEPS_PER_MIN = 800,
  parameter int ACCEL_TICK_US     = 20000,
  parameter int DIR_BITS          = 240
) (
  input  logic                in_valid,
  output logic                in_stall,
  input  hbss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hbss_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                clk,
  input  logic                rst_n
);

  localparam logic [31:0] INIT_PERIOD = 32'(60000000 / MIN_STEPS_PER_MIN);
  localparam logic [31:0] ACCEL_TICK  = 32'(ACCEL_TICK_US);
  localparam logic [31:0] HALF_TICK   = 32'(ACCEL_TICK_US / 2);
  localparam logic [7:0]  DIR_MASK    = 8'(DIR_BITS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] w_cfg_r [4];
  logic [7:0]  pulse_r, base_r;
  logic [15:0] weight_r [4];
  logic signed [17:0] acc_r [4];
  logic [3:0]  active_r;
  logic [15:0] major_r;
  logic [7:0]  pin_r;
  logic        inv_r;
  logic [31:0] period_r, cruise_r, rstep_r, rate_r, trap_r, delay_r;
  logic        ov_r;
  hbss_pkg::out_item_t od_r;

  logic        div_start, div_busy;
  logic [31:0] div_q;

  hbss_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(hbss_pkg::USEC_PER_MIN), .divisor(rate_r),
    .busy(div_busy), .quotient(div_q)
  );

  logic        take;
  logic        out_free;
  logic [3:0]  amask;
  logic [15:0] wsel [4];
  logic [15:0] maj;
  logic [3:0]  ls;
  logic [3:0]  smask;
  logic [3:0]  act_n;
  logic signed [17:0] acc_n [4];
  logic signed [17:0] sum [4];
  logic [31:0] init_p;
  logic [32:0] tsum;
  logic [31:0] trap_n;
  logic [32:0] rsum;
  logic [31:0] per_new;

  function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [7:0] b);
    return (a > {24'd0, b}) ? a - {24'd0, b} : 32'd0;
  endfunction

  assign out_free  = !ov_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign take      = in_valid && !in_stall;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    amask = in_data.axis_mask;
    maj   = '0;
    for (int i = 0; i < 4; i++) begin
      wsel[i] = amask[i] ? w_cfg_r[i] : 16'd0;
      if (wsel[i] > maj) maj = wsel[i];
    end
    init_p = (INIT_PERIOD < in_data.cruise_period_us) ? in_data.cruise_period_us
                                                      : INIT_PERIOD;
    ls    = in_data.limit_bits ^ {4{inv_r}};
    smask = '0;
    act_n = active_r;
    for (int i = 0; i < 4; i++) begin
      sum[i]   = acc_r[i] + $signed({2'b00, weight_r[i]});
      acc_n[i] = acc_r[i];
      if (active_r[i]) begin
        acc_n[i] = sum[i];
        if (sum[i] > 18'sd0) begin
          if (ls[i]) smask[i] = 1'b1;
          else act_n[i] = 1'b0;
          acc_n[i] = sum[i] - $signed({2'b00, major_r});
        end
      end
    end
    tsum   = {1'b0, trap_r} + {1'b0, period_r};
    trap_n = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
    rsum   = {1'b0, rate_r} + {1'b0, rstep_r};
    per_new = (rate_r == 32'd0) ? 32'hFFFF_FFFF : div_q;
    if (per_new < cruise_r) per_new = cruise_r;
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (take && in_data.req_type == hbss_pkg::REQ_TICK && act_n != 4'd0 &&
            !in_data.abort && period_r > cruise_r && trap_n > ACCEL_TICK)
          state_nxt = ST_DIV;
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!div_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ov_r     <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        w_cfg_r[i]  <= '0;
        weight_r[i] <= '0;
        acc_r[i]    <= '0;
      end
      pulse_r  <= 8'd10;
      base_r   <= '0;
      active_r <= '0;
      major_r  <= '0;
      pin_r    <= '0;
      inv_r    <= 1'b0;
      period_r <= '0;
      cruise_r <= '0;
      rstep_r  <= '0;
      rate_r   <= '0;
      trap_r   <= '0;
      delay_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (!take && !out_stall) ov_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          hbss_pkg::CFG_STEPS_X: w_cfg_r[0] <= cfg_data;
          hbss_pkg::CFG_STEPS_Y: w_cfg_r[1] <= cfg_data;
          hbss_pkg::CFG_STEPS_Z: w_cfg_r[2] <= cfg_data;
          hbss_pkg::CFG_STEPS_U: w_cfg_r[3] <= cfg_data;
          hbss_pkg::CFG_PULSE:   pulse_r    <= cfg_data[7:0];
          hbss_pkg::CFG_BASE:    base_r     <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (take) begin
        if (in_data.req_type == hbss_pkg::REQ_START) begin
          active_r <= amask;
          major_r  <= maj;
          for (int i = 0; i < 4; i++) begin
            weight_r[i] <= wsel[i];
            acc_r[i]    <= -$signed({3'b000, maj[15:1]});
          end
          pin_r    <= base_r ^ (in_data.positive_dir ? 8'd0 : DIR_MASK);
          inv_r    <= in_data.invert_limits;
          cruise_r <= in_data.cruise_period_us;
          rstep_r  <= in_data.rate_increment;
          period_r <= init_p;
          rate_r   <= '0;
          trap_r   <= HALF_TICK;
          delay_r  <= sub_sat(init_p, pulse_r);
          ov_r     <= 1'b1;
          od_r.step_mask           <= '0;
          od_r.pin_word            <= base_r ^ (in_data.positive_dir ? 8'd0 : DIR_MASK);
          od_r.post_pulse_delay_us <= sub_sat(init_p, pulse_r);
          od_r.done_res            <= (amask == 4'd0);
        end else begin
          active_r <= act_n;
          for (int i = 0; i < 4; i++) acc_r[i] <= acc_n[i];
          ov_r          <= 1'b1;
          od_r.pin_word <= pin_r;
          if (act_n == 4'd0 || in_data.abort) begin
            od_r.step_mask           <= '0;
            od_r.post_pulse_delay_us <= '0;
            od_r.done_res            <= 1'b1;
          end else begin
            od_r.step_mask           <= smask;
            od_r.post_pulse_delay_us <= delay_r;
            od_r.done_res            <= 1'b0;
            if (period_r > cruise_r) begin
              if (trap_n > ACCEL_TICK) begin
                trap_r <= trap_n - ACCEL_TICK;
                rate_r <= rsum[32] ? 32'hFFFF_FFFF : rsum[31:0];
              end else begin
                trap_r <= trap_n;
              end
            end
          end
        end
      end
      if (state_r == ST_FIN && !div_busy) begin
        period_r <= per_new;
        delay_r  <= sub_sat(per_new, pulse_r);
      end
    end
  end

`ifndef SYNTH
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !take) else $error("item taken during divide");
  a_div_after: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |=> div_busy) else $error("divider not started");
  a_done_nostep: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && od_r.done_res |-> od_r.step_mask == 4'd0) else $error("step on done");
  a_period_cruise: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == ST_FIN && state_r == ST_IDLE |-> period_r >= cruise_r)
    else $error("period below cruise");
`endif

endmodule

// ===== hdl/hbss_div.sv =====
// ----------------------------------------------------------------------------
// hbss_div: bit-serial divider
// Restoring division of a 32-bit dividend by a 32-bit divisor, one quotient
// bit per cycle. A zero divisor yields all ones.
// ----------------------------------------------------------------------------
module hbss_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [32:0] trial;
  logic [32:0] diff;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, quo_r[31]};
    diff    = trial - {1'b0, dvs_r};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = 6'd32;
    end else if (cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (cnt_r != 6'd0);
  assign quotient = quo_r;

endmodule
